// ===== design/rwl_pkg.sv =====
// Shared constants, types and helpers for the readers-writer lock manager.
package rwl_pkg;

    localparam int QUEUE_DEPTH     = 16;
    localparam int REQUESTER_COUNT = 64;

    localparam int AGENT_W   = 6;
    localparam int READERS_W = 7;
    localparam int QW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [READERS_W-1:0] READER_MAX = 7'd127;

    typedef enum logic [1:0] {
        OP_START_READ  = 2'd0,
        OP_END_READ    = 2'd1,
        OP_START_WRITE = 2'd2,
        OP_END_WRITE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_GRANTED  = 2'd0,
        ST_QUEUED   = 2'd1,
        ST_RELEASED = 2'd2,
        ST_REJECTED = 2'd3
    } status_t;

    typedef struct packed {
        logic               writer;
        logic [AGENT_W-1:0] agent;
    } entry_t;

    typedef struct packed {
        logic          en;
        logic [QW-1:0] addr;
        entry_t        data;
    } qwr_t;

    function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
        logic [QW-1:0] r;
        if (p == QW'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

endpackage

// ===== design/fifo_readers_writer_lock_core.sv =====
// Readers-writer lock manager with a FIFO wait queue: top level.
//
// Requests enter on the s_ channel (opcode, requester); results leave on the
// m_ channel, one transfer per result. Every request yields an acknowledgement
// (granted, queued, released or rejected), followed by one granted result per
// requester woken from the queue; tlast marks the final result of a request.
// The acknowledgement is registered and appears the cycle after the request
// transfer. Wake-ups follow at one per cycle while the receiver takes them, for
// 0 to QUEUE_DEPTH woken requesters per request; the queue RAM with its two
// registered read ports (head and head+1) sets that pace.
// A new request is taken once the output register is empty or its result is
// taken in the same cycle, and never while wake-ups are still pending.
// When the receiver stalls, the output register holds, wake-ups pause and
// s_tready stays low.
// Reset clears the reader count, writer flag and queue pointers; the queue
// RAM is not cleared, as only occupied entries are ever read.
module fifo_readers_writer_lock_core
    import rwl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [1:0] opcode, [7:2] requester
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [5:0] agent, [7:6] status
    output logic [0:0] m_tuser,   // [0] access_kind
    output logic       m_tlast
);

    typedef enum logic {
        S_IDLE,
        S_WAKE
    } state_t;

    state_t                state_reg,   state_next;
    logic [READERS_W-1:0]  readers_reg, readers_next;
    logic                  writer_reg,  writer_next;
    logic [QW-1:0]         head_reg,    head_next;
    logic [CW-1:0]         count_reg,   count_next;
    logic                  run_reg,     run_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [AGENT_W-1:0]    agent_reg,   agent_next;
    logic                  kind_reg,    kind_next;
    status_t               status_reg,  status_next;
    logic                  last_reg,    last_next;

    qwr_t                  wr;
    entry_t                head_entry;
    entry_t                next_entry;
    logic [CW:0]           tail_sum;
    logic [QW-1:0]         tail_addr;
    opcode_t               op;
    logic [AGENT_W-1:0]    requester;
    logic                  out_free;
    logic                  wake_last;

    assign op        = opcode_t'(s_tdata[1:0]);
    assign requester = s_tdata[7:2];
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;

    assign tail_sum  = (CW+1)'(head_reg) + (CW+1)'(count_reg);
    assign tail_addr = QW'((tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                           (tail_sum - (CW+1)'(QUEUE_DEPTH)) : tail_sum);

    assign wake_last = !run_reg || head_entry.writer ||
                       (count_reg == CW'(1)) || next_entry.writer;

    rwl_queue_ram u_ram (
        .clk      (clk),
        .wr       (wr),
        .rd_addr0 (head_next),
        .rd_addr1 (ptr_inc(head_next)),
        .rd_data0 (head_entry),
        .rd_data1 (next_entry)
    );

    always_comb
    begin
        state_next    = state_reg;
        readers_next  = readers_reg;
        writer_next   = writer_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        run_next      = run_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        agent_next    = agent_reg;
        kind_next     = kind_reg;
        status_next   = status_reg;
        last_next     = last_reg;
        wr            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    m_tvalid_next = 1'b1;
                    agent_next    = requester;
                    kind_next     = op[1];
                    status_next   = ST_REJECTED;
                    last_next     = 1'b1;
                    if (int'(requester) >= REQUESTER_COUNT)
                    begin
                        status_next = ST_REJECTED;
                    end
                    else
                    begin
                        unique case (op)
                            OP_START_READ:
                            begin
                                if (writer_reg || (count_reg != '0))
                                begin
                                    if (count_reg != CW'(QUEUE_DEPTH))
                                    begin
                                        wr.en       = 1'b1;
                                        wr.addr     = tail_addr;
                                        wr.data     = '{writer: 1'b0, agent: requester};
                                        count_next  = count_reg + 1'b1;
                                        status_next = ST_QUEUED;
                                    end
                                end
                                else if (readers_reg != READER_MAX)
                                begin
                                    readers_next = readers_reg + 1'b1;
                                    status_next  = ST_GRANTED;
                                end
                            end
                            OP_END_READ:
                            begin
                                if (readers_reg != '0)
                                begin
                                    readers_next = readers_reg - 1'b1;
                                    status_next  = ST_RELEASED;
                                    if ((readers_reg == READERS_W'(1)) && (count_reg != '0))
                                    begin
                                        last_next  = 1'b0;
                                        run_next   = 1'b0;
                                        state_next = S_WAKE;
                                    end
                                end
                            end
                            OP_START_WRITE:
                            begin
                                if (writer_reg || (readers_reg != '0))
                                begin
                                    if (count_reg != CW'(QUEUE_DEPTH))
                                    begin
                                        wr.en       = 1'b1;
                                        wr.addr     = tail_addr;
                                        wr.data     = '{writer: 1'b1, agent: requester};
                                        count_next  = count_reg + 1'b1;
                                        status_next = ST_QUEUED;
                                    end
                                end
                                else
                                begin
                                    writer_next = 1'b1;
                                    status_next = ST_GRANTED;
                                end
                            end
                            OP_END_WRITE:
                            begin
                                if (writer_reg)
                                begin
                                    writer_next = 1'b0;
                                    status_next = ST_RELEASED;
                                    if (count_reg != '0)
                                    begin
                                        last_next  = 1'b0;
                                        run_next   = 1'b1;
                                        state_next = S_WAKE;
                                    end
                                end
                            end
                            default:
                            begin
                                status_next = ST_REJECTED;
                            end
                        endcase
                    end
                end
            end
            S_WAKE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    agent_next    = head_entry.agent;
                    kind_next     = head_entry.writer;
                    status_next   = ST_GRANTED;
                    last_next     = wake_last;
                    head_next     = ptr_inc(head_reg);
                    count_next    = count_reg - 1'b1;
                    if (head_entry.writer)
                        writer_next = 1'b1;
                    else if (readers_reg != READER_MAX)
                        readers_next = readers_reg + 1'b1;
                    if (wake_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            readers_reg  <= '0;
            writer_reg   <= 1'b0;
            head_reg     <= '0;
            count_reg    <= '0;
            run_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            readers_reg  <= readers_next;
            writer_reg   <= writer_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            run_reg      <= run_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        agent_reg  <= agent_next;
        kind_reg   <= kind_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {status_reg, agent_reg};
    assign m_tuser[0] = kind_reg;
    assign m_tlast    = last_reg;

endmodule

// ===== design/rwl_queue_ram.sv =====
// Wait queue storage: one write port, two registered read ports with write forwarding.
module rwl_queue_ram
    import rwl_pkg::*;
(
    input  logic          clk,
    input  qwr_t          wr,
    input  logic [QW-1:0] rd_addr0,
    input  logic [QW-1:0] rd_addr1,
    output entry_t        rd_data0,
    output entry_t        rd_data1
);

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data0_reg;
    entry_t rd_data1_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (wr.en && (wr.addr == rd_addr0))
            rd_data0_reg <= wr.data;
        else
            rd_data0_reg <= mem[rd_addr0];
        if (wr.en && (wr.addr == rd_addr1))
            rd_data1_reg <= wr.data;
        else
            rd_data1_reg <= mem[rd_addr1];
    end

    assign rd_data0 = rd_data0_reg;
    assign rd_data1 = rd_data1_reg;

endmodule

// ===== design/rwl_checker.sv =====
// Port-level assertions for the lock manager, bound to the top level.
module rwl_checker
    import rwl_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser,
    input logic       m_tlast
);

    // ack is registered and valid in the cycle after the request
    a_ack_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("no acknowledgement after request transfer");

    // more results pending: no new request taken
    a_no_take_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("request taken while wake-ups are pending");

    // queued and rejected never wake anyone
    a_final_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && ((m_tdata[7:6] == ST_QUEUED) || (m_tdata[7:6] == ST_REJECTED)))
        |-> m_tlast)
        else $error("queued or rejected result not marked last");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
        (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind fifo_readers_writer_lock_core rwl_checker u_rwl_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the readers-writer lock manager: predicted results vs. output stream.
module testbench;
    import rwl_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 40;

    typedef struct packed {
        logic [AGENT_W-1:0] agent;
        logic               kind;
        status_t            status;
        logic               last;
    } lock_result_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = '0;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic [0:0] m_tuser;
    logic       m_tlast;

    // lock state as predicted
    int unsigned held_readers = 0;
    logic        writer_holds = 1'b0;
    entry_t      wait_line [QUEUE_DEPTH];
    int unsigned line_head    = 0;
    int unsigned line_count   = 0;

    lock_result_t step_results [$];
    lock_result_t pending_results [$];
    lock_result_t oldest_result;

    int idle_level       = 1;
    int mismatches       = 0;
    int requests_sent    = 0;
    int results_checked  = 0;
    int peak_waiting     = 0;
    int longest_wake_run = 0;
    int quiet_cycles     = 0;

    fifo_readers_writer_lock_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 clk = ~clk;

    function automatic int idle_draw();
        int gap;
        gap = 0;
        if (idle_level >= 2)
            gap = $urandom_range(0, 14);
        else if (idle_level == 1 && $urandom_range(0, 3) == 0)
            gap = $urandom_range(0, 14);
        return gap;
    endfunction

    function void add_result(logic [AGENT_W-1:0] agent, logic kind, status_t st);
        lock_result_t r;
        r.agent  = agent;
        r.kind   = kind;
        r.status = st;
        r.last   = 1'b0;
        step_results.push_back(r);
    endfunction

    function void enqueue_waiter(logic [AGENT_W-1:0] who, logic writer);
        entry_t e;
        e.writer = writer;
        e.agent  = who;
        wait_line[(line_head + line_count) % QUEUE_DEPTH] = e;
        line_count++;
    endfunction

    function void wake_head_waiter();
        entry_t e;
        e = wait_line[line_head];
        line_head = (line_head + 1) % QUEUE_DEPTH;
        line_count--;
        if (e.writer)
            writer_holds = 1'b1;
        else if (held_readers < READER_MAX)
            held_readers++;
        add_result(e.agent, e.writer, ST_GRANTED);
    endfunction

    // Updates the lock state for one request and queues the results it causes.
    function void predict_lock_step(opcode_t op, logic [AGENT_W-1:0] who);
        logic         kind;
        lock_result_t r;
        kind = op[1];
        step_results.delete();
        if (int'(who) >= REQUESTER_COUNT) begin
            add_result(who, kind, ST_REJECTED);
        end
        else begin
            case (op)
                OP_START_READ:
                begin
                    if (writer_holds || line_count != 0) begin
                        if (line_count >= QUEUE_DEPTH)
                            add_result(who, 1'b0, ST_REJECTED);
                        else
                        begin
                            enqueue_waiter(who, 1'b0);
                            add_result(who, 1'b0, ST_QUEUED);
                        end
                    end
                    else if (held_readers >= READER_MAX) begin
                        add_result(who, 1'b0, ST_REJECTED);
                    end
                    else begin
                        held_readers++;
                        add_result(who, 1'b0, ST_GRANTED);
                    end
                end
                OP_END_READ:
                begin
                    if (held_readers == 0) begin
                        add_result(who, 1'b0, ST_REJECTED);
                    end
                    else begin
                        held_readers--;
                        add_result(who, 1'b0, ST_RELEASED);
                        if (held_readers == 0 && line_count != 0)
                            wake_head_waiter();
                    end
                end
                OP_START_WRITE:
                begin
                    if (writer_holds || held_readers != 0) begin
                        if (line_count >= QUEUE_DEPTH)
                            add_result(who, 1'b1, ST_REJECTED);
                        else
                        begin
                            enqueue_waiter(who, 1'b1);
                            add_result(who, 1'b1, ST_QUEUED);
                        end
                    end
                    else begin
                        writer_holds = 1'b1;
                        add_result(who, 1'b1, ST_GRANTED);
                    end
                end
                default:
                begin
                    if (!writer_holds) begin
                        add_result(who, 1'b1, ST_REJECTED);
                    end
                    else begin
                        writer_holds = 1'b0;
                        add_result(who, 1'b1, ST_RELEASED);
                        if (line_count != 0) begin
                            if (wait_line[line_head].writer)
                                wake_head_waiter();
                            else
                            begin
                                while (line_count != 0 && !wait_line[line_head].writer)
                                    wake_head_waiter();
                            end
                        end
                    end
                end
            endcase
        end
        r = step_results.pop_back();
        r.last = 1'b1;
        step_results.push_back(r);
        if (step_results.size() - 1 > longest_wake_run)
            longest_wake_run = step_results.size() - 1;
        if (line_count > peak_waiting)
            peak_waiting = line_count;
        foreach (step_results[i])
            pending_results.push_back(step_results[i]);
    endfunction

    task automatic send_request(opcode_t op, logic [AGENT_W-1:0] who);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {who, op};
        do @(posedge clk); while (!s_tready);
        predict_lock_step(op, who);
        requests_sent++;
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // Releases whatever is held until the lock is free and nobody waits.
    task automatic drain_lock();
        while (writer_holds || held_readers != 0 || line_count != 0) begin
            if (writer_holds)
                send_request(OP_END_WRITE, AGENT_W'($urandom_range(0, 63)));
            else if (held_readers != 0)
                send_request(OP_END_READ, AGENT_W'($urandom_range(0, 63)));
            else
                break;
        end
    endtask

    task automatic test_grants_and_releases();
        send_request(OP_END_READ, 6'd3);      // bad read release
        send_request(OP_END_WRITE, 6'd60);    // bad write release
        send_request(OP_START_READ, 6'd0);
        send_request(OP_START_READ, 6'd63);
        send_request(OP_START_WRITE, 6'd21);
        send_request(OP_START_READ, 6'd42);   // queued behind a waiter
        send_request(OP_END_READ, 6'd0);
        send_request(OP_END_READ, 6'd63);     // last reader wakes writer
        send_request(OP_START_READ, 6'd5);
        send_request(OP_START_READ, 6'd6);
        send_request(OP_START_WRITE, 6'd7);
        send_request(OP_START_READ, 6'd8);
        send_request(OP_END_WRITE, 6'd55);    // non-owner release, reader run up to writer
        send_request(OP_START_WRITE, 6'd9);
        send_request(OP_END_READ, 6'd42);
        send_request(OP_END_READ, 6'd5);
        send_request(OP_END_READ, 6'd6);
        send_request(OP_END_WRITE, 6'd7);
        send_request(OP_END_READ, 6'd8);
        send_request(OP_END_WRITE, 6'd9);
        send_request(OP_END_WRITE, 6'd9);
    endtask

    task automatic test_full_queue();
        logic writer;
        for (int round = 0; round < 2; round++) begin
            send_request(OP_START_WRITE, AGENT_W'($urandom_range(0, 63)));
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (round == 0)
                    writer = 1'b0;
                else if (i == 0)
                    writer = 1'b1;
                else
                    writer = 1'($urandom_range(0, 1));
                send_request(writer ? OP_START_WRITE : OP_START_READ,
                             AGENT_W'($urandom_range(0, 63)));
            end
            send_request(OP_START_READ, 6'd63);
            send_request(OP_START_WRITE, 6'd0);
            send_request(OP_END_WRITE, AGENT_W'($urandom_range(0, 63)));
            drain_lock();
        end
    endtask

    task automatic test_reader_limit();
        idle_level = 0;
        repeat (READER_MAX) send_request(OP_START_READ, AGENT_W'($urandom_range(0, 63)));
        send_request(OP_START_READ, 6'd17);   // count full
        send_request(OP_START_WRITE, 6'd40);
        send_request(OP_START_READ, 6'd41);
        idle_level = 1;
        drain_lock();
    endtask

    task automatic run_lock_traffic(int count, int start_pct);
        int      pick;
        opcode_t op;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                op = opcode_t'($urandom_range(0, 3));
            else if (pick < 6 + start_pct)
                op = $urandom_range(0, 1) ? OP_START_WRITE : OP_START_READ;
            else if (writer_holds)
                op = OP_END_WRITE;
            else if (held_readers != 0)
                op = OP_END_READ;
            else
                op = $urandom_range(0, 1) ? OP_END_WRITE : OP_END_READ;
            send_request(op, AGENT_W'($urandom_range(0, 63)));
        end
    endtask

    task automatic test_random_traffic();
        idle_level = 2;
        run_lock_traffic(60, 55);
        wait_results_done();
        idle_level = 0;
        run_lock_traffic(50, 50);
        idle_level = 1;
        run_lock_traffic(40, 40);
        drain_lock();
    endtask

    function void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    initial
    begin : result_sink
        int stall;
        forever begin
            stall = idle_draw();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected transfer: expected none, actual agent=%0d kind=%0d status=%0d last=%0d",
                         $time, m_tdata[5:0], m_tuser[0], m_tdata[7:6], m_tlast);
            end
            else begin
                oldest_result = pending_results.pop_front();
                check_field("agent", oldest_result.agent, m_tdata[5:0]);
                check_field("access_kind", oldest_result.kind, m_tuser[0]);
                check_field("status", oldest_result.status, m_tdata[7:6]);
                check_field("last", oldest_result.last, m_tlast);
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_grants_and_releases();
        drain_lock();
        test_full_queue();
        test_reader_limit();
        test_random_traffic();
        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d lock requests, checked %0d results (full queue, bad releases, reader limit).",
                 requests_sent, results_checked);
        $display("Peak waiting requesters %0d, longest wake-up run %0d.",
                 peak_waiting, longest_wake_run);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== fifo_readers_writer_lock_core.f =====
design/rwl_pkg.sv
design/rwl_queue_ram.sv
design/fifo_readers_writer_lock_core.sv
design/rwl_checker.sv
sim/testbench.sv
